// ===== rtl/core/ordered_dither_halftone_assert.svh =====
// ----------------------------------------------------------------------------
// ordered_dither_halftone_assert.svh
// Assertion macros for the halftone RTL. Sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_DITHER_HALFTONE_ASSERT_SVH
`define ORDERED_DITHER_HALFTONE_ASSERT_SVH

// same-cycle implication
`define ODH_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ODH_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/odh_pkg.sv =====
// ----------------------------------------------------------------------------
// odh_pkg
// Types, codes and constants of the ordered dither halftone block.
// ----------------------------------------------------------------------------
package odh_pkg;

  localparam int MATRIX_SIZE_DEF = 64;
  localparam int ENTRY_BITS_DEF  = 16;

  localparam int DIM_W      = 7;
  localparam int LINE_W     = 16;
  localparam int FIELD_W    = 16;
  localparam int PIXEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SCALED_W   = 12;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_PIXEL   = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 2'd2;

  localparam logic [DIM_W-1:0]  DIM_RST        = 7'd1;
  localparam logic [LINE_W-1:0] LINE_WIDTH_RST = 16'd640;

  localparam logic [PIXEL_W-1:0]  PIXEL_WHITE = 8'hFF;
  localparam logic [PIXEL_W-1:0]  PIXEL_BLACK = 8'h00;
  localparam logic [SCALED_W-1:0] SCALED_MAX  = 12'd4095;

  // p * 4095 / 255 = 16p + p/17, with p/17 as (p * 241) >> 12
  localparam logic [15:0] FRAC_MUL   = 16'd241;
  localparam int          FRAC_SHIFT = 12;

  typedef struct packed {
    logic [1:0]         func;
    logic [FIELD_W-1:0] entry_value;
    logic [PIXEL_W-1:0] pixel_in;
  } odh_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               row_end;
  } odh_out_t;

  typedef struct packed {
    logic load;
    logic pixel;
    logic restart;
  } odh_step_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } odh_state_t;

endpackage

// ===== rtl/core/ordered_dither_halftone.sv =====
// ----------------------------------------------------------------------------
// ordered_dither_halftone
// Bilevel ordered dither with a tiled threshold matrix held in block RAM.
// ----------------------------------------------------------------------------
// A pixel item issues, on its transfer, the read of its matrix entry from
// the threshold RAM (registered read) and moves the block to ST_EVAL,
// which runs the scale, multiply and compare and loads the output register.
// Load and restart items give no result. A new item is taken while a
// result waits in the output register; a pixel then holds in ST_EVAL
// until that register frees. The RAM needs no clearing after reset, so
// items are taken from the first cycle out of reset.
// ----------------------------------------------------------------------------
module ordered_dither_halftone #(
  parameter int MATRIX_SIZE = odh_pkg::MATRIX_SIZE_DEF,
  parameter int ENTRY_BITS  = odh_pkg::ENTRY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  odh_pkg::odh_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output odh_pkg::odh_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [odh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [odh_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import odh_pkg::*;

  `include "ordered_dither_halftone_assert.svh"

  localparam int DEPTH  = MATRIX_SIZE * MATRIX_SIZE;
  localparam int ADDR_W = (MATRIX_SIZE > 1) ? $clog2(DEPTH) : 1;

  odh_state_t            state_r, state_nxt;
  logic [DIM_W-1:0]      mw_r, mw_nxt;
  logic [DIM_W-1:0]      mh_r, mh_nxt;
  logic [LINE_W-1:0]     lw_r, lw_nxt;
  logic                  out_valid_r, out_valid_nxt;
  odh_out_t              out_data_r;
  logic [PIXEL_W-1:0]    pix_r;
  logic                  row_end_r;

  logic                  accept;
  odh_step_t             step;
  logic                  out_free;
  logic                  eval_fire;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ENTRY_BITS-1:0] entry;
  logic [ENTRY_BITS-1:0] raw;
  logic [ENTRY_BITS-1:0] largest;
  logic                  last;
  logic                  single;
  logic                  bright;

  assign accept   = in_valid && !in_stall;
  assign entry    = ENTRY_BITS'(in_data.entry_value);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    step = '0;
    unique case (in_data.func)
      FUNC_LOAD:    step.load    = accept;
      FUNC_PIXEL:   step.pixel   = accept;
      FUNC_RESTART: step.restart = accept;
      default:      step         = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (step.pixel) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b0;
    eval_fire = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_EVAL: begin
        in_stall  = 1'b1;
        eval_fire = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    mw_nxt = mw_r;
    mh_nxt = mh_r;
    lw_nxt = lw_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATRIX_WIDTH:  mw_nxt = cfg_wdata[DIM_W-1:0];
        CFG_MATRIX_HEIGHT: mh_nxt = cfg_wdata[DIM_W-1:0];
        CFG_LINE_WIDTH:    lw_nxt = cfg_wdata[LINE_W-1:0];
        default:           lw_nxt = lw_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eval_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mw_r        <= DIM_RST;
      mh_r        <= DIM_RST;
      lw_r        <= LINE_WIDTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mw_r        <= mw_nxt;
      mh_r        <= mh_nxt;
      lw_r        <= lw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.pixel) begin
      pix_r     <= in_data.pixel_in;
      row_end_r <= last;
    end
    if (eval_fire) begin
      out_data_r.pixel_out <= bright ? PIXEL_WHITE : PIXEL_BLACK;
      out_data_r.row_end   <= row_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  odh_seq #(
    .MATRIX_SIZE (MATRIX_SIZE),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .entry         (entry),
    .matrix_width  (mw_r),
    .matrix_height (mh_r),
    .line_width    (lw_r),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .largest       (largest),
    .last          (last),
    .single        (single)
  );

  odh_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (step.load),
    .waddr (wr_addr),
    .wdata (entry),
    .re    (step.pixel),
    .raddr (rd_addr),
    .rdata (raw)
  );

  odh_eval #(
    .ENTRY_BITS (ENTRY_BITS)
  ) u_eval (
    .pixel   (pix_r),
    .raw     (raw),
    .largest (largest),
    .single  (single),
    .bright  (bright)
  );

  `ODH_ASSERT_NXT(a_pixel_enters_eval, step.pixel, state_r == ST_EVAL, "pixel transfer did not start evaluation")
  `ODH_ASSERT_NXT(a_eval_holds, (state_r == ST_EVAL) && !out_free, (state_r == ST_EVAL) && $stable(pix_r) && $stable(raw), "evaluation lost its operands while the output was blocked")
  `ODH_ASSERT_IMP(a_result_source, $rose(out_valid_r), $past(eval_fire), "result appeared without an evaluation")
  `ODH_ASSERT_IMP(a_bilevel_out, out_valid_r, (out_data_r.pixel_out == PIXEL_WHITE) || (out_data_r.pixel_out == PIXEL_BLACK), "output pixel is not bilevel")

endmodule

// ===== rtl/core/odh_ram.sv =====
// ----------------------------------------------------------------------------
// odh_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module odh_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 4096,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/odh_seq.sv =====
// ----------------------------------------------------------------------------
// odh_seq
// Load pointer, tile position, pixel column and largest entry tracking.
// ----------------------------------------------------------------------------
module odh_seq #(
  parameter int  MATRIX_SIZE = odh_pkg::MATRIX_SIZE_DEF,
  parameter int  ENTRY_BITS  = odh_pkg::ENTRY_BITS_DEF,
  localparam int IDX_W       = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1,
  localparam int ADDR_W      = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE * MATRIX_SIZE) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  odh_pkg::odh_step_t            step,
  input  logic [ENTRY_BITS-1:0]         entry,
  input  logic [odh_pkg::DIM_W-1:0]     matrix_width,
  input  logic [odh_pkg::DIM_W-1:0]     matrix_height,
  input  logic [odh_pkg::LINE_W-1:0]    line_width,
  output logic [ADDR_W-1:0]             wr_addr,
  output logic [ADDR_W-1:0]             rd_addr,
  output logic [ENTRY_BITS-1:0]         largest,
  output logic                          last,
  output logic                          single
);

  import odh_pkg::*;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MATRIX_SIZE);

  logic [IDX_W-1:0]      lcol_r, lcol_nxt;
  logic [IDX_W-1:0]      lrow_r, lrow_nxt;
  logic [IDX_W-1:0]      tcol_r, tcol_nxt;
  logic [IDX_W-1:0]      trow_r, trow_nxt;
  logic [LINE_W-1:0]     pcol_r, pcol_nxt;
  logic [ENTRY_BITS-1:0] largest_r, largest_nxt;
  logic [DIM_W-1:0]      w_c;
  logic [DIM_W-1:0]      h_c;
  logic [LINE_W-1:0]     lw_c;
  logic                  lcol_wrap;
  logic                  lrow_wrap;
  logic                  tcol_wrap;
  logic                  trow_wrap;

  always_comb begin
    w_c  = (matrix_width == '0) ? DIM_RST :
           ((matrix_width > DIM_MAX) ? DIM_MAX : matrix_width);
    h_c  = (matrix_height == '0) ? DIM_RST :
           ((matrix_height > DIM_MAX) ? DIM_MAX : matrix_height);
    lw_c = (line_width == '0) ? LINE_W'(1) : line_width;

    lcol_wrap = (8'(lcol_r) + 8'd1) >= 8'(w_c);
    lrow_wrap = (8'(lrow_r) + 8'd1) >= 8'(h_c);
    tcol_wrap = (8'(tcol_r) + 8'd1) >= 8'(w_c);
    trow_wrap = (8'(trow_r) + 8'd1) >= 8'(h_c);
    last      = (17'(pcol_r) + 17'd1) >= 17'(lw_c);
    single    = (w_c == DIM_RST) && (h_c == DIM_RST);

    wr_addr = ADDR_W'(int'(lrow_r) * MATRIX_SIZE + int'(lcol_r));
    rd_addr = ADDR_W'(int'(trow_r) * MATRIX_SIZE + int'(tcol_r));
    largest = largest_r;
  end

  always_comb begin
    lcol_nxt    = lcol_r;
    lrow_nxt    = lrow_r;
    tcol_nxt    = tcol_r;
    trow_nxt    = trow_r;
    pcol_nxt    = pcol_r;
    largest_nxt = largest_r;
    if (step.restart) begin
      lcol_nxt    = '0;
      lrow_nxt    = '0;
      tcol_nxt    = '0;
      trow_nxt    = '0;
      pcol_nxt    = '0;
      largest_nxt = '0;
    end else if (step.load) begin
      if (entry > largest_r) begin
        largest_nxt = entry;
      end
      if (lcol_wrap) begin
        lcol_nxt = '0;
        lrow_nxt = lrow_wrap ? '0 : lrow_r + IDX_W'(1);
      end else begin
        lcol_nxt = lcol_r + IDX_W'(1);
      end
    end else if (step.pixel) begin
      if (last) begin
        pcol_nxt = '0;
        tcol_nxt = '0;
        trow_nxt = trow_wrap ? '0 : trow_r + IDX_W'(1);
      end else begin
        pcol_nxt = pcol_r + LINE_W'(1);
        tcol_nxt = tcol_wrap ? '0 : tcol_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcol_r    <= '0;
      lrow_r    <= '0;
      tcol_r    <= '0;
      trow_r    <= '0;
      pcol_r    <= '0;
      largest_r <= '0;
    end else begin
      lcol_r    <= lcol_nxt;
      lrow_r    <= lrow_nxt;
      tcol_r    <= tcol_nxt;
      trow_r    <= trow_nxt;
      pcol_r    <= pcol_nxt;
      largest_r <= largest_nxt;
    end
  end

endmodule

// ===== rtl/core/odh_eval.sv =====
// ----------------------------------------------------------------------------
// odh_eval
// Scales a grey pixel and compares it with the threshold from a raw matrix
// entry, by cross multiplication or, for a 1x1 matrix, directly.
// ----------------------------------------------------------------------------
module odh_eval #(
  parameter int ENTRY_BITS = odh_pkg::ENTRY_BITS_DEF
) (
  input  logic [odh_pkg::PIXEL_W-1:0] pixel,
  input  logic [ENTRY_BITS-1:0]       raw,
  input  logic [ENTRY_BITS-1:0]       largest,
  input  logic                        single,
  output logic                        bright
);

  import odh_pkg::*;

  localparam int EXT_W  = ENTRY_BITS + 1;
  localparam int NUM_W  = ENTRY_BITS + 13;
  localparam int PROD_W = ENTRY_BITS + 14;

  logic [15:0]         frac_prod;
  logic [SCALED_W-1:0] scaled;
  logic [12:0]         scaled_inc;
  logic [EXT_W-1:0]    den;
  logic [EXT_W-1:0]    raw_inc;
  logic [NUM_W-1:0]    num;
  logic [PROD_W-1:0]   prod;

  always_comb begin
    frac_prod  = 16'(pixel) * FRAC_MUL;
    scaled     = {pixel, 4'b0000} + SCALED_W'(frac_prod >> FRAC_SHIFT);
    scaled_inc = 13'(scaled) + 13'd1;
    den        = EXT_W'(largest) + EXT_W'(2);
    raw_inc    = EXT_W'(raw) + EXT_W'(1);
    num        = {raw_inc, 12'h000};
    prod       = PROD_W'(scaled_inc) * PROD_W'(den);
    if (single) begin
      bright = PROD_W'(scaled) >= PROD_W'(raw);
    end else begin
      bright = (scaled == SCALED_MAX) || (prod > PROD_W'(num));
    end
  end

endmodule
